[hw/rtl/bdq_pkg.sv]
// bdq_pkg: shared types and constants for the bounded deque
`timescale 1ns / 1ps

package bdq_pkg;

   localparam int DEPTH_DEF   = 16;
   localparam int VALUE_W     = 32;
   localparam int LIMIT_W     = 5;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 2;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_LEFT  = 2'd0,
      OP_PUSH_RIGHT = 2'd1,
      OP_POP_LEFT   = 2'd2,
      OP_POP_RIGHT  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_PUSHED = 2'd0,
      ST_POPPED = 2'd1,
      ST_FULL   = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

   // per-cycle command broadcast to every cell of the row
   typedef struct packed {
      logic shift_right;
      logic fill_tail;
      logic shift_left;
      logic drop_tail;
   } cell_cmd_type;

endpackage

[hw/rtl/bdq_req_if.sv]
// bdq_req_if: request channel carrying the operation and the push value
`timescale 1ns / 1ps

interface bdq_req_if;
   import bdq_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     req_type;
   logic signed [VALUE_W-1:0] push_value;

   modport source (output valid, output req_type, output push_value, input ready);
   modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

[hw/rtl/bdq_rsp_if.sv]
// bdq_rsp_if: response channel carrying status, value and the end touched
`timescale 1ns / 1ps

interface bdq_rsp_if;
   import bdq_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic signed [VALUE_W-1:0] result_value;
   logic                      at_right_end;

   modport source (output valid, output status, output result_value, output at_right_end,
                   input ready);
   modport sink   (input valid, input status, input result_value, input at_right_end,
                   output ready);
endinterface

[hw/rtl/bdq_cell.sv]
// bdq_cell: one slot of the deque row, shifts with its neighbors
`timescale 1ns / 1ps

module bdq_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  bdq_pkg::cell_cmd_type           cmd,
   input  logic [bdq_pkg::VALUE_W-1:0]     push_value,
   input  logic [bdq_pkg::VALUE_W-1:0]     left_value,
   input  logic                            left_valid,
   input  logic [bdq_pkg::VALUE_W-1:0]     right_value,
   input  logic                            right_valid,
   input  logic [bdq_pkg::VALUE_W-1:0]     tail_in,
   output logic [bdq_pkg::VALUE_W-1:0]     value,
   output logic                            valid,
   output logic [bdq_pkg::VALUE_W-1:0]     tail_out
);
   import bdq_pkg::*;

   logic [VALUE_W-1:0] value_ff, value_in;
   logic               valid_ff, valid_in;
   logic               is_tail;

   // the last occupied cell is the right end
   assign is_tail = valid_ff && !right_valid;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (cmd.shift_right) begin
         value_in = left_value;
         valid_in = left_valid;
      end else if (cmd.shift_left) begin
         value_in = right_value;
         valid_in = right_valid;
      end else if (cmd.fill_tail && left_valid && !valid_ff) begin
         value_in = push_value;
         valid_in = 1'b1;
      end else if (cmd.drop_tail && is_tail) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value    = value_ff;
   assign valid    = valid_ff;
   assign tail_out = tail_in | (is_tail ? value_ff : '0);
endmodule

[hw/rtl/bounded_deque_unit.sv]
// bounded_deque_unit: double-ended queue built from a row of shifting cells
//
// req_ch carries one transaction per operation: req_type selects push left,
// push right, pop left or pop right, push_value is stored on a push.
// rsp_ch returns exactly one transaction per request, in order: status
// (pushed, popped, full, empty), result_value (echoed or popped value, zero
// on full and empty) and at_right_end (the end the request named).
// csr_we / csr_wdata write the capacity limit; values above DEPTH act as DEPTH.
// The response is registered and valid in the cycle after request acceptance.
// Throughput is one transaction per cycle while responses are taken: the cell
// row shifts or fills on acceptance, one output register freeing as it is taken.
// When the receiver stalls, the response register holds and req_ch.ready
// drops until it is taken, so nothing is lost.
// Reset empties the queue (all cells invalid, occupancy zero) and sets the
// capacity limit to 16; stored values are not cleared.
`timescale 1ns / 1ps

module bounded_deque_unit #(
   parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   bdq_req_if.sink                       req_ch,
   bdq_rsp_if.source                     rsp_ch,
   input  logic                          csr_we,
   input  logic [bdq_pkg::LIMIT_W-1:0]   csr_wdata
);
   import bdq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   logic [LIMIT_W-1:0]  limit_ff;
   logic [CNT_W-1:0]    occ_ff, occ_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                rsp_right_ff, rsp_right_in;

   logic                accept, full, empty, is_push;
   op_type              op;
   cell_cmd_type        cmd;

   // position 0 feeds the left cell, position DEPTH+1 is past the right cell
   logic [VALUE_W-1:0]  chain_value [DEPTH+2];
   logic [DEPTH+1:0]    chain_valid;
   logic [VALUE_W-1:0]  tail_acc [DEPTH+1];

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign op           = op_type'(req_ch.req_type);
   assign is_push      = (op == OP_PUSH_LEFT) || (op == OP_PUSH_RIGHT);
   assign full         = (CMP_W'(occ_ff) >= CMP_W'(limit_ff)) || (occ_ff == CNT_W'(DEPTH));
   assign empty        = (occ_ff == '0);

   assign chain_value[0]       = req_ch.push_value;
   assign chain_valid[0]       = 1'b1;
   assign chain_value[DEPTH+1] = '0;
   assign chain_valid[DEPTH+1] = 1'b0;
   assign tail_acc[0]          = '0;

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         bdq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .cmd         (cmd),
            .push_value  (req_ch.push_value),
            .left_value  (chain_value[g]),
            .left_valid  (chain_valid[g]),
            .right_value (chain_value[g+2]),
            .right_valid (chain_valid[g+2]),
            .tail_in     (tail_acc[g]),
            .value       (chain_value[g+1]),
            .valid       (chain_valid[g+1]),
            .tail_out    (tail_acc[g+1])
         );
      end
   endgenerate

   always_comb begin
      cmd           = '0;
      occ_in        = occ_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_right_in  = rsp_right_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_right_in = req_ch.req_type[0];
         rsp_value_in = '0;
         if (is_push) begin
            if (full) begin
               rsp_status_in = ST_FULL;
            end else begin
               rsp_status_in   = ST_PUSHED;
               rsp_value_in    = req_ch.push_value;
               occ_in          = occ_ff + CNT_W'(1);
               cmd.shift_right = (op == OP_PUSH_LEFT);
               cmd.fill_tail   = (op == OP_PUSH_RIGHT);
            end
         end else begin
            if (empty) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               rsp_status_in  = ST_POPPED;
               occ_in         = occ_ff - CNT_W'(1);
               cmd.shift_left = (op == OP_POP_LEFT);
               cmd.drop_tail  = (op == OP_POP_RIGHT);
               rsp_value_in   = (op == OP_POP_LEFT) ? chain_value[1] : tail_acc[DEPTH];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_right_ff  <= rsp_right_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.result_value = rsp_value_ff;
   assign rsp_ch.at_right_end = rsp_right_ff;

   // occupied cells always form a run from the left and match the count
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(chain_valid[DEPTH:1]) == occ_ff)
      else $error("cell valid bits disagree with occupancy");

   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      chain_valid[1] == (occ_ff != '0))
      else $error("left cell valid disagrees with occupancy");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(DEPTH))
      else $error("occupancy above depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      accept && is_push && !full |=> occ_ff == $past(occ_ff) + CNT_W'(1))
      else $error("accepted push did not grow the queue");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      accept && is_push && full |=> rsp_ch.status == ST_FULL && occ_ff == $past(occ_ff))
      else $error("push on full queue changed state");
endmodule
